@@ src/dpsd_pkg.sv @@
// ----------------------------------------------------------------------------
// dpsd_pkg
// Shared types and constants of the delta patch stream decoder.
// ----------------------------------------------------------------------------
package dpsd_pkg;

   // widths fixed by the field definitions
   localparam int PLEN_W     = 21;
   localparam int SIZE_W     = 24;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int OPND_W     = 64;

   // register reset values
   localparam logic [PLEN_W-1:0] PLEN_RESET = 21'd13;
   localparam logic [SIZE_W-1:0] SRC_RESET  = 24'hC00000;
   localparam logic [SIZE_W-1:0] TGT_RESET  = 24'hC11460;

   // header layout
   localparam logic [3:0] MAGIC_BYTES = 4'd4;
   localparam logic [3:0] SRC_LAST    = 4'd7;
   localparam logic [3:0] TGT_LAST    = 4'd11;
   localparam logic [3:0] COPY_LAST   = 4'd7;
   localparam logic [3:0] LITLEN_LAST = 4'd3;
   localparam int         COPY_OPND   = 8;
   localparam int         LIT_OPND    = 4;

   // magic bytes, first byte in lane 0
   localparam logic [3:0][7:0] MAGIC = {8'h31, 8'h50, 8'h45, 8'h47};

   // opcodes
   localparam logic [7:0] OP_COPY    = 8'h00;
   localparam logic [7:0] OP_LITERAL = 8'h01;
   localparam logic [7:0] OP_END     = 8'hFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATCH_LENGTH = 2'd0,
      REG_SOURCE_SIZE  = 2'd1,
      REG_TARGET_SIZE  = 2'd2
   } csr_reg_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_OPCODE = 3'd1,
      PH_COPY   = 3'd2,
      PH_LITLEN = 3'd3,
      PH_DATA   = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_STATUS  = 2'd0,
      KIND_COPY    = 2'd1,
      KIND_LITERAL = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_OK       = 4'd0,
      ST_MAGIC    = 4'd1,
      ST_SIZE     = 4'd2,
      ST_OPCODE   = 4'd3,
      ST_TRUNC    = 4'd4,
      ST_RANGE    = 4'd5,
      ST_OVERFLOW = 4'd6,
      ST_LIT_END  = 4'd7,
      ST_TERM     = 4'd8,
      ST_SHORT    = 4'd9
   } status_type;

   typedef struct packed {
      logic [PLEN_W-1:0] patch_length;
      logic [SIZE_W-1:0] source_size;
      logic [SIZE_W-1:0] target_size;
   } dpsd_cfg_type;

   typedef struct packed {
      logic              emit;
      kind_type          kind;
      logic [SIZE_W-1:0] copy_offset;
      logic [SIZE_W-1:0] copy_length;
      logic [7:0]        literal_value;
      logic              finished;
      status_type        status;
   } dpsd_result_type;

endpackage

@@ src/dpsd_decoder.sv @@
// ----------------------------------------------------------------------------
// dpsd_decoder
// Patch parsing state and per-byte result logic, one byte per step.
// ----------------------------------------------------------------------------
module dpsd_decoder import dpsd_pkg::*; #(
   parameter int MAX_PATCH_BYTES = 1048576,
   parameter int SIZE_BITS       = 24
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      patch_byte,
   input  dpsd_cfg_type    cfg,
   output dpsd_result_type result
);

   localparam int PW  = $clog2(MAX_PATCH_BYTES + 1);
   localparam int CLW = (PW > PLEN_W) ? PW : PLEN_W;
   localparam logic [SIZE_W-1:0] SIZE_MASK =
      (SIZE_BITS >= SIZE_W) ? {SIZE_W{1'b1}} : SIZE_W'((64'd1 << SIZE_BITS) - 64'd1);

   phase_type         phase_ff, phase_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [OPND_W-1:0] opnd_ff, opnd_in;
   logic [SIZE_W-1:0] oc_ff, oc_in;
   logic [PW-1:0]     litrem_ff, litrem_in;

   logic [PW-1:0]     len;
   logic [SIZE_W-1:0] src, tgt;
   logic [PW:0]       pos_inc;
   logic              last;
   logic [PW-1:0]     remaining;
   logic [31:0]       word;
   logic [31:0]       copy_off, copy_cnt;
   logic              copy_range_bad, copy_ovf_bad, lit_end_bad, lit_ovf_bad;
   logic [2:0]        byte_sel;
   logic              err, term, idle, fin;

   // clamp the configured length to the supported maximum
   assign len = (CLW'(cfg.patch_length) > CLW'(MAX_PATCH_BYTES)) ?
                PW'(MAX_PATCH_BYTES) : PW'(cfg.patch_length);
   assign src = cfg.source_size & SIZE_MASK;
   assign tgt = cfg.target_size & SIZE_MASK;

   assign pos_inc   = {1'b0, pos_ff} + {{PW{1'b0}}, 1'b1};
   assign last      = pos_inc >= {1'b0, len};
   assign remaining = last ? '0 : PW'({1'b0, len} - pos_inc);

   // little-endian operands, completed by the byte now in hand
   assign word     = {patch_byte, opnd_ff[23:0]};
   assign copy_off = opnd_ff[31:0];
   assign copy_cnt = {patch_byte, opnd_ff[55:32]};

   assign copy_range_bad = ({1'b0, copy_off} + {1'b0, copy_cnt}) > 33'(src);
   assign copy_ovf_bad   = (33'(oc_ff) + {1'b0, copy_cnt}) > 33'(tgt);
   assign lit_end_bad    = word > 32'(remaining);
   assign lit_ovf_bad    = (33'(oc_ff) + {1'b0, word}) > 33'(tgt);

   assign byte_sel = (phase_ff == PH_COPY) ? cnt_ff[2:0] : {1'b0, cnt_ff[1:0]};

   // result of the current byte
   always_comb begin
      result               = '0;
      result.kind          = KIND_STATUS;
      result.status        = ST_OK;
      err                  = 1'b0;
      term                 = 1'b0;
      idle                 = 1'b0;
      case (phase_ff)
         PH_HEADER: begin
            if (cnt_ff < MAGIC_BYTES) begin
               if (patch_byte != MAGIC[cnt_ff[1:0]]) begin
                  err           = 1'b1;
                  result.status = ST_MAGIC;
               end
            end else if ((cnt_ff == SRC_LAST && word != 32'(src)) ||
                         (cnt_ff == TGT_LAST && word != 32'(tgt))) begin
               err           = 1'b1;
               result.status = ST_SIZE;
            end
         end
         PH_OPCODE: begin
            if (patch_byte == OP_COPY || patch_byte == OP_LITERAL) begin
               if (remaining < ((patch_byte == OP_COPY) ? PW'(COPY_OPND) : PW'(LIT_OPND)))
               begin
                  err           = 1'b1;
                  result.status = ST_TRUNC;
               end
            end else if (patch_byte == OP_END) begin
               term = 1'b1;
               if (last) begin
                  result.status = (oc_ff == tgt) ? ST_OK : ST_SHORT;
               end else begin
                  result.status = ST_TERM;
               end
            end else begin
               err           = 1'b1;
               result.status = ST_OPCODE;
            end
         end
         PH_COPY: begin
            if (cnt_ff == COPY_LAST) begin
               if (copy_range_bad) begin
                  err           = 1'b1;
                  result.status = ST_RANGE;
               end else if (copy_ovf_bad) begin
                  err           = 1'b1;
                  result.status = ST_OVERFLOW;
               end else begin
                  result.kind        = KIND_COPY;
                  result.copy_offset = copy_off[SIZE_W-1:0];
                  result.copy_length = copy_cnt[SIZE_W-1:0];
               end
            end
         end
         PH_LITLEN: begin
            if (cnt_ff == LITLEN_LAST) begin
               if (lit_end_bad) begin
                  err           = 1'b1;
                  result.status = ST_LIT_END;
               end else if (lit_ovf_bad) begin
                  err           = 1'b1;
                  result.status = ST_OVERFLOW;
               end
            end
         end
         PH_DATA: begin
            result.kind          = KIND_LITERAL;
            result.literal_value = patch_byte;
         end
         default: begin
            idle = 1'b1;
         end
      endcase
      fin = !idle && (err || term || last);
      if (fin && !err && !term) begin
         result.status = ST_TRUNC;
      end
      result.finished = fin;
      result.emit     = fin || (result.kind != KIND_STATUS);
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      opnd_in   = opnd_ff;
      oc_in     = oc_ff;
      litrem_in = litrem_ff;
      if (step) begin
         pos_in                   = pos_inc[PW-1:0];
         opnd_in[byte_sel*8 +: 8] = patch_byte;
         case (phase_ff)
            PH_HEADER: begin
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == TGT_LAST) begin
                  phase_in = PH_OPCODE;
               end
            end
            PH_OPCODE: begin
               cnt_in = '0;
               if (patch_byte == OP_COPY) begin
                  phase_in = PH_COPY;
               end else if (patch_byte == OP_LITERAL) begin
                  phase_in = PH_LITLEN;
               end
            end
            PH_COPY: begin
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == COPY_LAST) begin
                  cnt_in   = '0;
                  phase_in = PH_OPCODE;
                  oc_in    = oc_ff + copy_cnt[SIZE_W-1:0];
               end
            end
            PH_LITLEN: begin
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == LITLEN_LAST) begin
                  cnt_in = '0;
                  if (word == '0) begin
                     phase_in = PH_OPCODE;
                  end else begin
                     litrem_in = word[PW-1:0];
                     phase_in  = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               oc_in = oc_ff + SIZE_W'(1);
               if (litrem_ff != '0) begin
                  litrem_in = litrem_ff - PW'(1);
               end
               if (litrem_ff <= PW'(1)) begin
                  phase_in = PH_OPCODE;
               end
            end
            PH_DONE: begin
               pos_in = pos_ff;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
         if (fin) begin
            phase_in = PH_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         cnt_ff    <= '0;
         pos_ff    <= '0;
         oc_ff     <= '0;
         litrem_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         pos_ff    <= pos_in;
         oc_ff     <= oc_in;
         litrem_ff <= litrem_in;
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
   end

endmodule

@@ src/delta_patch_stream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// delta_patch_stream_decoder_top
// Byte-serial delta patch decoder: header check, copy and literal commands.
// ----------------------------------------------------------------------------
// usage
//   req_*  : patch bytes, one per transaction, in stream order
//   rsp_*  : copy commands, literal bytes and the single final status
//   csr_*  : write-only registers (patch length, source size, target size),
//            written between patches while no transaction is in flight
// timing
//   a byte is captured in an input register, decoded in one pass and the
//   result lands in the output register, which drives rsp_valid. a new
//   byte is taken every cycle while the output is not stalled.
//   bytes that cause no result (header, operands, anything after the final
//   status) are absorbed without a rsp transaction
// stalls
//   the input register doubles as a skid slot, so one more byte is taken
//   while a result waits on rsp_ready; after that req_ready drops
// reset
//   synchronous; returns the registers to their defaults and the parser to
//   the start of a header. no clearing pass is needed
// ----------------------------------------------------------------------------
module delta_patch_stream_decoder_top import dpsd_pkg::*; #(
   parameter int MAX_PATCH_BYTES = 1048576,
   parameter int SIZE_BITS       = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   // patch byte stream
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_patch_byte,
   // results
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [SIZE_W-1:0]     rsp_copy_offset,
   output logic [SIZE_W-1:0]     rsp_copy_length,
   output logic [7:0]            rsp_literal_value,
   output logic                  rsp_finished,
   output logic [3:0]            rsp_status,
   // register writes
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   // configuration registers
   logic [PLEN_W-1:0] plen_ff, plen_in;
   logic [SIZE_W-1:0] src_ff, src_in;
   logic [SIZE_W-1:0] tgt_ff, tgt_in;

   // input stage
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // output stage
   logic            rsp_vld_ff, rsp_vld_in;
   dpsd_result_type rsp_ff, rsp_in;

   logic            advance;
   logic            step;
   logic            req_fire;
   dpsd_cfg_type    cfg;
   dpsd_result_type result;

   // register writes, unknown indexes are dropped
   always_comb begin
      plen_in = plen_ff;
      src_in  = src_ff;
      tgt_in  = tgt_ff;
      if (csr_write_enable) begin
         case (csr_reg_type'(csr_index))
            REG_PATCH_LENGTH: plen_in = csr_write_data[PLEN_W-1:0];
            REG_SOURCE_SIZE:  src_in  = csr_write_data[SIZE_W-1:0];
            REG_TARGET_SIZE:  tgt_in  = csr_write_data[SIZE_W-1:0];
            default: begin
               plen_in = plen_ff;
            end
         endcase
      end
   end

   assign cfg = '{patch_length: plen_ff, source_size: src_ff, target_size: tgt_ff};

   // the output slot frees when empty or when its transaction completes
   assign advance   = !rsp_vld_ff || rsp_ready;
   assign step      = in_vld_ff && advance;
   assign req_ready = !in_vld_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_vld_in  = req_fire || (in_vld_ff && !advance);
   assign in_byte_in = req_fire ? req_patch_byte : in_byte_ff;

   dpsd_decoder #(
      .MAX_PATCH_BYTES (MAX_PATCH_BYTES),
      .SIZE_BITS       (SIZE_BITS)
   ) u_decoder (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .patch_byte (in_byte_ff),
      .cfg        (cfg),
      .result     (result)
   );

   // load a result only for bytes that produce one
   assign rsp_vld_in = advance ? (step && result.emit) : rsp_vld_ff;
   assign rsp_in     = (advance && step) ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff    <= PLEN_RESET;
         src_ff     <= SRC_RESET;
         tgt_ff     <= TGT_RESET;
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         plen_ff    <= plen_in;
         src_ff     <= src_in;
         tgt_ff     <= tgt_in;
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_kind          = rsp_ff.kind;
   assign rsp_copy_offset   = rsp_ff.copy_offset;
   assign rsp_copy_length   = rsp_ff.copy_length;
   assign rsp_literal_value = rsp_ff.literal_value;
   assign rsp_finished      = rsp_ff.finished;
   assign rsp_status        = rsp_ff.status;

   // a non-final result always carries an ok status
   a_status_only_when_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_finished |-> rsp_status == ST_OK)
      else $error("non-final result with a status code");

   // a copy can only be final when the stream ran out on its last operand byte
   a_final_copy_truncated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished && rsp_kind == KIND_COPY |-> rsp_status == ST_TRUNC)
      else $error("final copy with an unexpected status");

   // nothing follows the final status
   a_silent_after_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_finished |=> !rsp_valid)
      else $error("result after the final status");

endmodule
